// ----- design/lik_pkg.sv -----
// Shared types, constants and tables for the three-joint leg solver.
package lik_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
    localparam int APB_ADDR_W = 5;

    localparam logic signed [14:0] DEG90 = 15'sd5760;
    localparam logic signed [14:0] DEG180 = 15'sd11520;
    localparam logic signed [24:0] Z_DEG90 = 25'sd5898240;

    localparam logic CMD_ABSOLUTE = 1'b0;
    localparam logic CMD_RELATIVE = 1'b1;

    typedef enum logic [2:0] {
        REG_FEMUR,
        REG_TIBIA,
        REG_MIRROR_X,
        REG_MIRROR_Y,
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_OFFSET_Z
    } lik_reg_t;

    typedef enum logic {
        OP_MUL,
        OP_SQRT
    } lik_op_t;

    typedef struct packed {
        logic    start;
        lik_op_t op;
    } lik_ser_req_t;

    typedef enum logic [1:0] {
        SER_IDLE,
        SER_MUL,
        SER_SQRT,
        SER_DONE
    } lik_ser_state_t;

    typedef enum logic [1:0] {
        COR_IDLE,
        COR_NORM,
        COR_ITER,
        COR_DONE
    } lik_cor_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OFS,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } lik_state_t;

    typedef enum logic [3:0] {
        STEP_HIP,
        STEP_SQX,
        STEP_SQY,
        STEP_SQZ,
        STEP_SQF,
        STEP_SQT,
        STEP_SUM,
        STEP_DIF,
        STEP_CHECK,
        STEP_C2,
        STEP_PROD,
        STEP_ROOT_R,
        STEP_ROOT_AT,
        STEP_ELEV,
        STEP_ANG_A,
        STEP_ANG_B
    } lik_step_t;

    // Arctangent of 2^-i in 1/65536 degree.
    function automatic logic [21:0] atan_entry(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0: v = 22'd2949120;
            5'd1: v = 22'd1740967;
            5'd2: v = 22'd919879;
            5'd3: v = 22'd466945;
            5'd4: v = 22'd234379;
            5'd5: v = 22'd117304;
            5'd6: v = 22'd58666;
            5'd7: v = 22'd29335;
            5'd8: v = 22'd14668;
            5'd9: v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/lik_if.sv -----
// Handshake channels for foot commands and joint results.
interface lik_cmd_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;

    modport source (output valid, command, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, command, pos_x, pos_y, pos_z, output ready);
endinterface

interface lik_joint_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] hip_angle;
    logic signed [14:0] thigh_angle;
    logic signed [14:0] knee_angle;
    logic               reachable;

    modport source (output valid, hip_angle, thigh_angle, knee_angle, reachable, input ready);
    modport sink (input valid, hip_angle, thigh_angle, knee_angle, reachable, output ready);
endinterface

// ----- design/lik_serial.sv -----
// Bit-serial multiplier and one-bit-per-cycle integer square root.
module lik_serial (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lik_pkg::lik_ser_req_t req,
    input  logic [63:0]          a_in,
    input  logic [33:0]          b_in,
    output logic                 done,
    output logic [63:0]          result
);
    import lik_pkg::*;

    lik_ser_state_t state_reg, state_next;
    logic [63:0] a_reg;
    logic [33:0] b_reg;
    logic [63:0] acc_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = acc_reg + bit_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SER_IDLE:
            begin
                if (req.start)
                begin
                    state_next = (req.op == OP_MUL) ? SER_MUL : SER_SQRT;
                end
            end
            SER_MUL:
            begin
                if (b_reg == '0)
                begin
                    state_next = SER_DONE;
                end
            end
            SER_SQRT:
            begin
                if (bit_reg == '0)
                begin
                    state_next = SER_DONE;
                end
            end
            SER_DONE: state_next = SER_IDLE;
            default: state_next = SER_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == SER_DONE);
        result = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SER_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SER_IDLE:
            begin
                a_reg <= a_in;
                b_reg <= b_in;
                acc_reg <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
            end
            SER_MUL:
            begin
                if (b_reg != '0)
                begin
                    if (b_reg[0])
                    begin
                        acc_reg <= acc_reg + a_reg;
                    end
                    a_reg <= {a_reg[62:0], 1'b0};
                    b_reg <= {1'b0, b_reg[33:1]};
                end
            end
            SER_SQRT:
            begin
                if (bit_reg != '0)
                begin
                    if (a_reg >= trial)
                    begin
                        a_reg <= a_reg - trial;
                        acc_reg <= {1'b0, acc_reg[63:1]} + bit_reg;
                    end
                    else
                    begin
                        acc_reg <= {1'b0, acc_reg[63:1]};
                    end
                    bit_reg <= {2'b00, bit_reg[63:2]};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- design/lik_cordic.sv -----
// Vectoring CORDIC arctangent in 1/64 degree with serial normalization.
module lik_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [33:0]        ax,
    input  logic signed [33:0] y,
    output logic               done,
    output logic signed [14:0] angle
);
    import lik_pkg::*;

    lik_cor_state_t state_reg, state_next;
    logic [33:0]        nx_reg;
    logic [33:0]        ny_reg;
    logic               neg_reg;
    logic signed [32:0] cx_reg;
    logic signed [32:0] cy_reg;
    logic signed [24:0] z_reg;
    logic [4:0]         i_reg;
    logic [33:0]        ay;
    logic [33:0]        m;
    logic               shift_down;
    logic               shift_up;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [24:0] tab;
    logic [23:0]        r;
    logic [14:0]        rr;
    logic [14:0]        mag;

    assign ay = y[33] ? 34'(-y) : 34'(y);
    assign m = (nx_reg > ny_reg) ? nx_reg : ny_reg;
    assign shift_down = |m[33:30];
    assign shift_up = ~m[29];
    assign dx = cy_reg >>> i_reg;
    assign dy = cx_reg >>> i_reg;
    assign tab = $signed({3'b000, atan_entry(i_reg)});

    always_comb
    begin
        r = z_reg[24] ? 24'd0 : z_reg[23:0];
        rr = 15'((25'(r) + 25'd512) >> 10);
        mag = (rr > 15'(DEG90)) ? 15'(DEG90) : rr;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            COR_IDLE:
            begin
                if (start)
                begin
                    state_next = (ax == '0) ? COR_DONE : COR_NORM;
                end
            end
            COR_NORM:
            begin
                if (!shift_down && !shift_up)
                begin
                    state_next = COR_ITER;
                end
            end
            COR_ITER:
            begin
                if (i_reg == 5'(CORDIC_STEPS - 1))
                begin
                    state_next = COR_DONE;
                end
            end
            COR_DONE: state_next = COR_IDLE;
            default: state_next = COR_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == COR_DONE);
        angle = neg_reg ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= COR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            COR_IDLE:
            begin
                neg_reg <= y[33];
                nx_reg <= ax;
                ny_reg <= ay;
                i_reg <= '0;
                z_reg <= (ay == '0) ? 25'sd0 : Z_DEG90;
            end
            COR_NORM:
            begin
                if (shift_down)
                begin
                    nx_reg <= {1'b0, nx_reg[33:1]};
                    ny_reg <= {1'b0, ny_reg[33:1]};
                end
                else if (shift_up)
                begin
                    nx_reg <= {nx_reg[32:0], 1'b0};
                    ny_reg <= {ny_reg[32:0], 1'b0};
                end
                else
                begin
                    cx_reg <= $signed({3'b000, nx_reg[29:0]});
                    cy_reg <= $signed({3'b000, ny_reg[29:0]});
                    z_reg <= '0;
                end
            end
            COR_ITER:
            begin
                if (!cy_reg[32])
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    z_reg <= z_reg + tab;
                end
                else
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    z_reg <= z_reg - tab;
                end
                i_reg <= i_reg + 5'd1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- design/leg_inverse_kinematics_3dof_unit.sv -----
// Top level of the three-joint leg inverse kinematics solver.
//
// A foot target item arrives on the cmd channel (valid/ready); command selects an
// absolute target or a move relative to the stored foot position. After the mirror
// bits and 16-bit saturation the position is stored, the offsets are added, and the
// hip, thigh and knee angles are solved. One result item leaves on the joint channel.
// The block works on one item at a time: cmd.ready is high only while it is idle.
// The steps run in turn on the shared bit-serial multiplier and square root unit
// (one multiplier bit or one root bit per cycle) and the shared CORDIC unit (serial
// normalization plus 16 iterations): eight squares, one product, two roots and four
// arctangents; an unreachable target skips everything after the reach test.
// A finished result sits in an output register; the next item is accepted while it
// waits, and the solver stalls at its end only if that register is still full.
// The user must write the registers over the APB port only while the block is idle; the block does not enforce it.
// Reset empties the output register, zeroes the stored foot position and loads the
// register reset values; it needs no clearing pass.
module leg_inverse_kinematics_3dof_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    lik_cmd_if.sink                        cmd,
    lik_joint_if.source                    joint,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lik_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import lik_pkg::*;

    lik_state_t state_reg, state_next;
    lik_step_t  step_reg;

    logic [14:0]        femur_reg;
    logic [14:0]        tibia_reg;
    logic               mirror_x_reg;
    logic               mirror_y_reg;
    logic signed [15:0] offset_x_reg;
    logic signed [15:0] offset_y_reg;
    logic signed [15:0] offset_z_reg;
    logic signed [15:0] foot_x_reg;
    logic signed [15:0] foot_y_reg;
    logic signed [15:0] foot_z_reg;

    logic signed [16:0] tx_reg;
    logic signed [16:0] ty_reg;
    logic signed [16:0] tz_reg;
    logic signed [14:0] hip_reg;
    logic [33:0]        axy_reg;
    logic [33:0]        d_reg;
    logic [29:0]        f2_reg;
    logic [29:0]        t2_reg;
    logic [31:0]        sum_reg;
    logic [29:0]        dif_reg;
    logic [32:0]        ca_reg;
    logic [32:0]        ea_reg;
    logic               obtuse_reg;
    logic               reach_reg;
    logic [63:0]        c2_reg;
    logic [63:0]        p_reg;
    logic [31:0]        r_reg;
    logic [20:0]        at_reg;
    logic signed [14:0] elev_reg;
    logic signed [14:0] ang_a_reg;
    logic signed [14:0] ang_b_reg;

    logic               out_valid_reg;
    logic signed [14:0] out_hip_reg;
    logic signed [14:0] out_thigh_reg;
    logic signed [14:0] out_knee_reg;
    logic               out_reach_reg;

    logic               cfg_write;
    lik_reg_t           cfg_index;
    logic               accept;
    logic               out_load;
    logic               step_cordic;
    logic               unit_done;
    lik_ser_req_t       ser_req;
    logic [63:0]        ser_a;
    logic [33:0]        ser_b;
    logic               ser_done;
    logic [63:0]        ser_result;
    logic               cor_start;
    logic [33:0]        cor_ax;
    logic signed [33:0] cor_y;
    logic               cor_done;
    logic signed [14:0] cor_angle;

    logic [16:0]        abs_tx;
    logic [16:0]        abs_ty;
    logic [16:0]        abs_tz;
    logic [15:0]        f_plus_t;
    logic [14:0]        f_minus_t;
    logic [63:0]        radicand;
    logic signed [35:0] c_val;
    logic signed [35:0] e_val;
    logic               reach_now;

    function automatic logic signed [15:0] foot_step(input logic signed [15:0] foot,
                                                     input logic signed [15:0] pos,
                                                     input logic mirror,
                                                     input logic rel);
        logic signed [16:0] p;
        logic signed [17:0] s;
        p = mirror ? -17'(pos) : 17'(pos);
        s = (rel == CMD_RELATIVE) ? 18'(foot) + 18'(p) : 18'(p);
        if (s > 18'sd32767)
        begin
            return 16'sh7fff;
        end
        else if (s < -18'sd32768)
        begin
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = lik_reg_t'(paddr[4:2]);
    assign accept = cmd.valid && cmd.ready;
    assign step_cordic = (step_reg == STEP_HIP) || (step_reg == STEP_ELEV) ||
                         (step_reg == STEP_ANG_A) || (step_reg == STEP_ANG_B);
    assign unit_done = step_cordic ? cor_done : ser_done;

    always_comb
    begin
        case (cfg_index)
            REG_FEMUR: prdata = {17'd0, femur_reg};
            REG_TIBIA: prdata = {17'd0, tibia_reg};
            REG_MIRROR_X: prdata = {31'd0, mirror_x_reg};
            REG_MIRROR_Y: prdata = {31'd0, mirror_y_reg};
            REG_OFFSET_X: prdata = 32'(offset_x_reg);
            REG_OFFSET_Y: prdata = 32'(offset_y_reg);
            REG_OFFSET_Z: prdata = 32'(offset_z_reg);
            default: prdata = '0;
        endcase
    end

    always_comb
    begin
        abs_tx = tx_reg[16] ? 17'(-tx_reg) : 17'(tx_reg);
        abs_ty = ty_reg[16] ? 17'(-ty_reg) : 17'(ty_reg);
        abs_tz = tz_reg[16] ? 17'(-tz_reg) : 17'(tz_reg);
        f_plus_t = 16'(femur_reg) + 16'(tibia_reg);
        f_minus_t = (femur_reg > tibia_reg) ? femur_reg - tibia_reg : tibia_reg - femur_reg;
        radicand = (p_reg >= c2_reg) ? p_reg - c2_reg : 64'd0;
        c_val = $signed({6'd0, f2_reg}) + $signed({2'd0, d_reg}) - $signed({6'd0, t2_reg});
        e_val = $signed({6'd0, f2_reg}) + $signed({6'd0, t2_reg}) - $signed({2'd0, d_reg});
        reach_now = (femur_reg != '0) && (tibia_reg != '0) && (d_reg != '0) &&
                    (d_reg <= 34'(sum_reg)) && (d_reg >= 34'(dif_reg));
    end

    always_comb
    begin
        ser_req.start = (state_reg == ST_ISSUE) && !step_cordic && (step_reg != STEP_CHECK);
        ser_req.op = OP_MUL;
        ser_a = '0;
        ser_b = '0;
        cor_ax = '0;
        cor_y = '0;
        case (step_reg)
            STEP_HIP:
            begin
                cor_ax = 34'(abs_tx);
                cor_y = tx_reg[16] ? -34'(ty_reg) : 34'(ty_reg);
            end
            STEP_SQX:
            begin
                ser_a = 64'(abs_tx);
                ser_b = 34'(abs_tx);
            end
            STEP_SQY:
            begin
                ser_a = 64'(abs_ty);
                ser_b = 34'(abs_ty);
            end
            STEP_SQZ:
            begin
                ser_a = 64'(abs_tz);
                ser_b = 34'(abs_tz);
            end
            STEP_SQF:
            begin
                ser_a = 64'(femur_reg);
                ser_b = 34'(femur_reg);
            end
            STEP_SQT:
            begin
                ser_a = 64'(tibia_reg);
                ser_b = 34'(tibia_reg);
            end
            STEP_SUM:
            begin
                ser_a = 64'(f_plus_t);
                ser_b = 34'(f_plus_t);
            end
            STEP_DIF:
            begin
                ser_a = 64'(f_minus_t);
                ser_b = 34'(f_minus_t);
            end
            STEP_C2:
            begin
                ser_a = 64'(ca_reg);
                ser_b = 34'(ca_reg);
            end
            STEP_PROD:
            begin
                ser_a = 64'(d_reg);
                ser_b = 34'(f2_reg);
            end
            STEP_ROOT_R:
            begin
                ser_req.op = OP_SQRT;
                ser_a = radicand;
            end
            STEP_ROOT_AT:
            begin
                ser_req.op = OP_SQRT;
                ser_a = {22'd0, axy_reg, 8'd0};
            end
            STEP_ELEV:
            begin
                cor_ax = 34'(at_reg);
                cor_y = {{13{tz_reg[16]}}, tz_reg, 4'd0};
            end
            STEP_ANG_A:
            begin
                cor_ax = 34'(ca_reg);
                cor_y = $signed({2'b00, r_reg});
            end
            STEP_ANG_B:
            begin
                cor_ax = 34'(ea_reg);
                cor_y = $signed({2'b00, r_reg});
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_OFS;
                end
            end
            ST_OFS: state_next = ST_ISSUE;
            ST_ISSUE:
            begin
                if (step_reg == STEP_CHECK)
                begin
                    state_next = reach_now ? ST_ISSUE : ST_DONE;
                end
                else
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (unit_done)
                begin
                    state_next = (step_reg == STEP_ANG_B) ? ST_DONE : ST_ISSUE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || joint.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.ready = (state_reg == ST_IDLE);
        cor_start = (state_reg == ST_ISSUE) && step_cordic;
        out_load = (state_reg == ST_DONE) && (!out_valid_reg || joint.ready);
        joint.valid = out_valid_reg;
        joint.hip_angle = out_hip_reg;
        joint.thigh_angle = out_thigh_reg;
        joint.knee_angle = out_knee_reg;
        joint.reachable = out_reach_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= STEP_HIP;
            out_valid_reg <= 1'b0;
            femur_reg <= 15'd1024;
            tibia_reg <= 15'd1024;
            mirror_x_reg <= 1'b0;
            mirror_y_reg <= 1'b0;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
            foot_x_reg <= '0;
            foot_y_reg <= '0;
            foot_z_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (joint.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FEMUR: femur_reg <= pwdata[14:0];
                    REG_TIBIA: tibia_reg <= pwdata[14:0];
                    REG_MIRROR_X: mirror_x_reg <= pwdata[0];
                    REG_MIRROR_Y: mirror_y_reg <= pwdata[0];
                    REG_OFFSET_X: offset_x_reg <= pwdata[15:0];
                    REG_OFFSET_Y: offset_y_reg <= pwdata[15:0];
                    REG_OFFSET_Z: offset_z_reg <= pwdata[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                foot_x_reg <= foot_step(foot_x_reg, cmd.pos_x, mirror_x_reg, cmd.command);
                foot_y_reg <= foot_step(foot_y_reg, cmd.pos_y, mirror_y_reg, cmd.command);
                foot_z_reg <= foot_step(foot_z_reg, cmd.pos_z, 1'b0, cmd.command);
            end
            if (state_reg == ST_OFS)
            begin
                step_reg <= STEP_HIP;
            end
            else if (state_reg == ST_ISSUE && step_reg == STEP_CHECK)
            begin
                step_reg <= STEP_C2;
            end
            else if (state_reg == ST_WAIT && unit_done && step_reg != STEP_ANG_B)
            begin
                step_reg <= lik_step_t'(step_reg + 4'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OFS)
        begin
            tx_reg <= 17'(foot_x_reg) + 17'(offset_x_reg);
            ty_reg <= 17'(foot_y_reg) + 17'(offset_y_reg);
            tz_reg <= 17'(foot_z_reg) + 17'(offset_z_reg);
            reach_reg <= 1'b0;
        end
        if (state_reg == ST_ISSUE && step_reg == STEP_CHECK)
        begin
            reach_reg <= reach_now;
            ca_reg <= c_val[35] ? 33'(-c_val) : 33'(c_val);
            ea_reg <= e_val[35] ? 33'(-e_val) : 33'(e_val);
            obtuse_reg <= e_val[35];
        end
        if (state_reg == ST_WAIT && unit_done)
        begin
            case (step_reg)
                STEP_HIP: hip_reg <= cor_angle;
                STEP_SQX: axy_reg <= ser_result[33:0];
                STEP_SQY: axy_reg <= axy_reg + ser_result[33:0];
                STEP_SQZ: d_reg <= axy_reg + ser_result[33:0];
                STEP_SQF: f2_reg <= ser_result[29:0];
                STEP_SQT: t2_reg <= ser_result[29:0];
                STEP_SUM: sum_reg <= ser_result[31:0];
                STEP_DIF: dif_reg <= ser_result[29:0];
                STEP_C2: c2_reg <= ser_result;
                STEP_PROD: p_reg <= {ser_result[61:0], 2'b00};
                STEP_ROOT_R: r_reg <= ser_result[31:0];
                STEP_ROOT_AT: at_reg <= ser_result[20:0];
                STEP_ELEV: elev_reg <= cor_angle;
                STEP_ANG_A: ang_a_reg <= cor_angle;
                STEP_ANG_B: ang_b_reg <= cor_angle;
                default:
                begin
                end
            endcase
        end
        if (out_load)
        begin
            out_hip_reg <= hip_reg;
            out_reach_reg <= reach_reg;
            out_thigh_reg <= reach_reg ? elev_reg + ang_a_reg : 15'sd0;
            out_knee_reg <= reach_reg ? (obtuse_reg ? DEG180 - ang_b_reg : ang_b_reg) : 15'sd0;
        end
    end

    lik_serial u_serial (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ser_req),
        .a_in   (ser_a),
        .b_in   (ser_b),
        .done   (ser_done),
        .result (ser_result)
    );

    lik_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .ax    (cor_ax),
        .y     (cor_y),
        .done  (cor_done),
        .angle (cor_angle)
    );

endmodule

// ----- design/lik_checker.sv -----
// Port-level checks for the leg solver, bound to its top level.
module lik_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [14:0] hip_angle,
    input logic signed [14:0] thigh_angle,
    input logic signed [14:0] knee_angle,
    input logic               reachable
);
    logic [1:0] pending_reg;
    logic       in_fire;
    logic       out_fire;

    assign in_fire = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(in_fire) - 2'(out_fire);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(hip_angle) && $stable(thigh_angle) &&
        $stable(knee_angle) && $stable(reachable))
        else $error("result item changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("second item accepted while solving");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result item without an accepted item");

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reachable |-> thigh_angle == 15'sd0 && knee_angle == 15'sd0)
        else $error("unreachable result carries joint angles");

endmodule

bind leg_inverse_kinematics_3dof_unit lik_checker u_lik_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cmd.valid),
    .in_ready    (cmd.ready),
    .out_valid   (joint.valid),
    .out_ready   (joint.ready),
    .hip_angle   (joint.hip_angle),
    .thigh_angle (joint.thigh_angle),
    .knee_angle  (joint.knee_angle),
    .reachable   (joint.reachable)
);

// ----- tb/lik_tb_pkg.sv -----
// Scoreboard class that predicts and checks the leg solver joint angles.
package lik_tb_pkg;

    import lik_pkg::*;

    typedef struct packed {
        logic               command;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
    } foot_cmd_t;

    typedef struct packed {
        logic signed [14:0] hip;
        logic signed [14:0] thigh;
        logic signed [14:0] knee;
        logic               reachable;
    } joint_res_t;

    class joint_scoreboard;
        longint   femur;
        longint   tibia;
        bit       mir_x;
        bit       mir_y;
        longint   ofs_x;
        longint   ofs_y;
        longint   ofs_z;
        longint   foot_x;
        longint   foot_y;
        longint   foot_z;
        joint_res_t pending[$];
        int       mismatches;
        int       failures;

        function new();
            femur = 1024;
            tibia = 1024;
            mir_x = 0;
            mir_y = 0;
            ofs_x = 0;
            ofs_y = 0;
            ofs_z = 0;
            foot_x = 0;
            foot_y = 0;
            foot_z = 0;
            mismatches = 0;
            failures = 0;
        endfunction

        function void set_reg(lik_reg_t r, logic [31:0] v);
            case (r)
                REG_FEMUR: femur = v[14:0];
                REG_TIBIA: tibia = v[14:0];
                REG_MIRROR_X: mir_x = v[0];
                REG_MIRROR_Y: mir_y = v[0];
                REG_OFFSET_X: ofs_x = $signed(v[15:0]);
                REG_OFFSET_Y: ofs_y = $signed(v[15:0]);
                REG_OFFSET_Z: ofs_z = $signed(v[15:0]);
                default: ;
            endcase
        endfunction

        static function longint clamp16(longint v);
            if (v > 32767)
            begin
                return 32767;
            end
            if (v < -32768)
            begin
                return -32768;
            end
            return v;
        endfunction

        static function longint shr_floor(longint v, int s);
            return v >>> s;
        endfunction

        static function longint int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
            begin
                b = b >> 2;
            end
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return longint'(res);
        endfunction

        static function longint arctan(longint unsigned ax, longint y);
            bit              neg;
            longint unsigned ay;
            longint unsigned m;
            longint          cx;
            longint          cy;
            longint          z;
            longint          r;
            longint          dx;
            longint          dy;
            neg = y < 0;
            ay = neg ? longint'(0) - y : y;
            z = 0;
            if (ax == 0)
            begin
                return (ay == 0) ? 0 : (neg ? -5760 : 5760);
            end
            m = (ax > ay) ? ax : ay;
            while (m >= (64'd1 << 30))
            begin
                ax = ax >> 1;
                ay = ay >> 1;
                m = m >> 1;
            end
            while (m < (64'd1 << 29))
            begin
                ax = ax << 1;
                ay = ay << 1;
                m = m << 1;
            end
            cx = ax;
            cy = ay;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0)
                begin
                    cx = cx + dx;
                    cy = cy - dy;
                    z = z + atan_entry(i[4:0]);
                end
                else
                begin
                    cx = cx - dx;
                    cy = cy + dy;
                    z = z - atan_entry(i[4:0]);
                end
            end
            r = (z < 0) ? 0 : z;
            r = (r + 512) >>> 10;
            if (r > 5760)
            begin
                r = 5760;
            end
            return neg ? -r : r;
        endfunction

        function void note_command(foot_cmd_t c);
            longint     px;
            longint     py;
            longint     pz;
            longint     tx;
            longint     ty;
            longint     tz;
            longint     d;
            longint     axy;
            longint     f2;
            longint     t2;
            longint     cc;
            longint     ee;
            longint     rr;
            longint     p;
            longint     elev;
            longint     a;
            longint     bq;
            longint     hip;
            longint     thigh;
            longint     knee;
            bit         ok;
            joint_res_t res;
            px = c.pos_x;
            py = c.pos_y;
            pz = c.pos_z;
            if (mir_x)
            begin
                px = -px;
            end
            if (mir_y)
            begin
                py = -py;
            end
            if (c.command == CMD_RELATIVE)
            begin
                foot_x = clamp16(foot_x + px);
                foot_y = clamp16(foot_y + py);
                foot_z = clamp16(foot_z + pz);
            end
            else
            begin
                foot_x = clamp16(px);
                foot_y = clamp16(py);
                foot_z = clamp16(pz);
            end
            tx = foot_x + ofs_x;
            ty = foot_y + ofs_y;
            tz = foot_z + ofs_z;
            hip = arctan((tx < 0) ? -tx : tx, (tx < 0) ? -ty : ty);
            axy = tx * tx + ty * ty;
            d = axy + tz * tz;
            f2 = femur * femur;
            t2 = tibia * tibia;
            ok = femur != 0 && tibia != 0 && d != 0 && d <= (femur + tibia) ** 2
                && d >= (femur - tibia) ** 2;
            thigh = 0;
            knee = 0;
            if (ok)
            begin
                cc = f2 + d - t2;
                ee = f2 + t2 - d;
                cc = (cc < 0) ? -cc : cc;
                ee = (ee < 0) ? -ee : ee;
                p = 4 * f2 * d;
                rr = int_sqrt((p >= cc * cc) ? p - cc * cc : 0);
                elev = arctan(int_sqrt(axy << 8), tz * 16);
                a = arctan(cc, rr);
                bq = arctan(ee, rr);
                knee = (d > f2 + t2) ? 11520 - bq : bq;
                thigh = elev + a;
            end
            res.hip = hip[14:0];
            res.thigh = thigh[14:0];
            res.knee = knee[14:0];
            res.reachable = ok;
            pending.push_back(res);
        endfunction

        function void check_joint(joint_res_t got);
            joint_res_t exp_res;
            if (pending.size() == 0)
            begin
                failures++;
                $display("ERROR: unexpected joint item %p", got);
                return;
            end
            exp_res = pending.pop_front();
            if (got !== exp_res)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: joint mismatch expected %p got %p", exp_res, got);
                end
            end
        endfunction
    endclass

endpackage

// ----- tb/tb.sv -----
// Top-level testbench for the three-joint leg solver.
module tb;

    import lik_pkg::*;
    import lik_tb_pkg::*;

    localparam int STALL_LIMIT = 40000;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    lik_cmd_if   cmd ();
    lik_joint_if joint ();

    joint_scoreboard sb;
    int  idle_cycles;
    bit  rx_hold;
    bit  stim_done;

    leg_inverse_kinematics_3dof_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .joint   (joint),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.command = 1'b0;
        cmd.pos_x = '0;
        cmd.pos_y = '0;
        cmd.pos_z = '0;
        joint.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rx_hold = 1'b0;
        stim_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && cmd.valid && cmd.ready)
        begin
            sb.note_command({cmd.command, cmd.pos_x, cmd.pos_y, cmd.pos_z});
        end
        if (rst_n && joint.valid && joint.ready)
        begin
            sb.check_joint({joint.hip_angle, joint.thigh_angle, joint.knee_angle,
                joint.reachable});
        end
    end

    // The receiver stalls on its own pattern, or holds off fully when asked.
    always @(posedge clk)
    begin
        if (!rst_n || rx_hold)
        begin
            joint.ready <= 1'b0;
        end
        else
        begin
            joint.ready <= ($urandom_range(0, 7) != 0) || ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (joint.valid && joint.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic reg_write(lik_reg_t r, logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * int'(r));
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(r, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send(logic c, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        cmd.valid <= 1'b1;
        cmd.command <= c;
        cmd.pos_x <= x;
        cmd.pos_y <= y;
        cmd.pos_z <= z;
        @(posedge clk);
        while (!cmd.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (600) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_pos(int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 16'($urandom);
        end
        return 16'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic random_items(int n, int span);
        int burst;
        for (int k = 0; k < n; k++)
        begin
            if (burst <= 0)
            begin
                cmd.valid <= 1'b0;
                repeat ($urandom_range(0, 400)) @(posedge clk);
                burst = $urandom_range(1, 12);
            end
            send(1'($urandom_range(0, 2) == 0), rand_pos(span), rand_pos(span),
                rand_pos(span));
            burst--;
        end
        drain();
    endtask

    initial
    begin
        int span;
        @(posedge rst_n);
        @(posedge clk);
        send(CMD_ABSOLUTE, 16'h0000, 16'h0000, 16'h0000);
        send(CMD_ABSOLUTE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send(CMD_RELATIVE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send(CMD_ABSOLUTE, 16'h8000, 16'h8000, 16'h8000);
        send(CMD_RELATIVE, 16'h8000, 16'h8000, 16'h8000);
        send(CMD_ABSOLUTE, 16'd1500, 16'd0, 16'd0);
        send(CMD_ABSOLUTE, 16'd0, 16'd1500, 16'd0);
        send(CMD_ABSOLUTE, 16'd0, 16'hFA24, 16'd0);
        send(CMD_ABSOLUTE, 16'd0, 16'd0, 16'd2048);
        send(CMD_ABSOLUTE, 16'd2048, 16'd0, 16'd0);
        send(CMD_ABSOLUTE, 16'd1, 16'd0, 16'd0);
        send(CMD_ABSOLUTE, 16'hF800, 16'd700, 16'hFC00);
        send(CMD_RELATIVE, 16'd100, 16'hFF00, 16'd50);
        send(CMD_ABSOLUTE, 16'd600, 16'd600, 16'hFC00);
        drain();
        reg_write(REG_MIRROR_X, 32'd1);
        reg_write(REG_MIRROR_Y, 32'd1);
        reg_write(REG_OFFSET_X, 32'h0000_7FFF);
        reg_write(REG_OFFSET_Y, 32'h0000_8000);
        reg_write(REG_OFFSET_Z, 32'h0000_7FFF);
        send(CMD_ABSOLUTE, 16'h8000, 16'h8000, 16'h7FFF);
        send(CMD_ABSOLUTE, 16'h7FFF, 16'h7FFF, 16'h8000);
        send(CMD_RELATIVE, 16'd10, 16'd10, 16'd10);
        drain();
        reg_write(REG_FEMUR, 32'd32767);
        reg_write(REG_TIBIA, 32'd1);
        reg_write(REG_OFFSET_X, 32'd0);
        reg_write(REG_OFFSET_Y, 32'd0);
        reg_write(REG_OFFSET_Z, 32'd0);
        send(CMD_ABSOLUTE, 16'h7FFF, 16'd0, 16'd0);
        send(CMD_ABSOLUTE, 16'h8000, 16'd0, 16'd0);
        send(CMD_ABSOLUTE, 16'h7FFE, 16'd0, 16'd0);
        drain();
        reg_write(REG_FEMUR, 32'd1);
        reg_write(REG_TIBIA, 32'd32767);
        reg_write(REG_MIRROR_X, 32'd0);
        reg_write(REG_MIRROR_Y, 32'd0);
        random_items(150, 32767);
        // Long receiver hold-off while the sender keeps offering items.
        fork
            begin
                rx_hold = 1'b1;
                repeat (3000) @(posedge clk);
                rx_hold = 1'b0;
            end
            random_items(20, 2000);
        join
        for (int ph = 0; ph < 6; ph++)
        begin
            reg_write(REG_FEMUR, $urandom_range(1, 4000));
            reg_write(REG_TIBIA, $urandom_range(1, 4000));
            reg_write(REG_MIRROR_X, $urandom_range(0, 1));
            reg_write(REG_MIRROR_Y, $urandom_range(0, 1));
            reg_write(REG_OFFSET_X, $urandom_range(0, 65535) & ((ph < 3) ? 32'h03FF : 32'hFFFF));
            reg_write(REG_OFFSET_Y, $urandom_range(0, 65535) & ((ph < 3) ? 32'h03FF : 32'hFFFF));
            reg_write(REG_OFFSET_Z, $urandom_range(0, 65535) & ((ph < 3) ? 32'h03FF : 32'hFFFF));
            span = int'((sb.femur + sb.tibia) / 2);
            random_items(190, span);
        end
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (600) @(posedge clk);
        if (sb.failures == 0 && sb.pending.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
